@@ src/tte_pkg.sv @@
// Shared types, constants and date helpers for the aging table.
package tte_pkg;

  localparam int unsigned ShortDepth = 16;
  localparam int unsigned LongDepth  = 32;
  localparam int unsigned PermDepth  = 16;
  localparam int unsigned ShortAw    = 4;
  localparam int unsigned LongAw     = 5;
  localparam int unsigned PermAw     = 4;

  localparam int unsigned StampW = 33;
  localparam int unsigned TagW   = 32;
  localparam int unsigned ToW    = 20;
  localparam int unsigned DaysW  = 23;

  localparam logic [StampW-1:0] StampMax = {StampW{1'b1}};
  localparam logic [ToW-1:0] ShortToReset = 20'd480;
  localparam logic [ToW-1:0] LongToReset  = 20'd43200;

  localparam logic [1:0] ModeAdd     = 2'd0;
  localparam logic [1:0] ModeCleanup = 2'd1;
  localparam logic [1:0] ModeRead    = 2'd2;
  localparam logic [1:0] ModeNone    = 2'd3;

  localparam logic [1:0] ClsShort = 2'd0;
  localparam logic [1:0] ClsLong  = 2'd1;
  localparam logic [1:0] ClsPerm  = 2'd2;
  localparam logic [1:0] ClsNone  = 2'd3;

  localparam logic [1:0] RegShortTo = 2'd0;
  localparam logic [1:0] RegLongTo  = 2'd1;

  // days before the first of each month in a common year
  function automatic logic [8:0] days_before(input logic [3:0] month);
    logic [8:0] d;
    begin
      case (month)
        4'd1:    d = 9'd0;
        4'd2:    d = 9'd31;
        4'd3:    d = 9'd59;
        4'd4:    d = 9'd90;
        4'd5:    d = 9'd120;
        4'd6:    d = 9'd151;
        4'd7:    d = 9'd181;
        4'd8:    d = 9'd212;
        4'd9:    d = 9'd243;
        4'd10:   d = 9'd273;
        4'd11:   d = 9'd304;
        default: d = 9'd334;
      endcase
      return d;
    end
  endfunction

  // datapath commands from the controller
  typedef struct packed {
    logic load;       // capture inputs, start date computation
    logic stamp_step; // advance stamp pipeline
    logic scan_clr;   // reset scan pointers
    logic scan_step;  // visit one short or long entry
    logic finish;     // register the result
  } tte_cmd_t;

  typedef struct packed {
    logic scan_done;
  } tte_sts_t;

endpackage

@@ src/timestamped_table_with_expiry.sv @@
// Top level: aging table with timeout expiry, APB registers and command port.
//  channel | handshake                     | payload
//  command | start while !busy             | mode_i .. entry_index_i
//  result  | done_o, one cycle             | ok_o .. out_minutes_o
//  config  | APB write, psel&penable&pwrite | pwdata[19:0] at paddr 0 or 4
// Add and read pass through the stamp states to the done state; cleanup also
// runs the one-entry-a-cycle compaction scan over the short and long entries
// between them. Reset clears fills and loads default timeouts. The result
// strobe cannot be stalled; busy holds off new transactions.
module timestamped_table_with_expiry import tte_pkg::*; (
  input  logic              clk_i,
  input  logic              rst_ni,
  input  logic              psel,
  input  logic              penable,
  input  logic              pwrite,
  input  logic [2:0]        paddr,
  input  logic [31:0]       pwdata,
  output logic [31:0]       prdata,
  output logic              pready,
  input  logic              start,
  output logic              busy,
  output logic              done_o,
  input  logic [1:0]        mode_i,
  input  logic [1:0]        mem_class_i,
  input  logic [TagW-1:0]   content_tag_i,
  input  logic [TagW-1:0]   related_tag_i,
  input  logic [13:0]       stamp_year_i,
  input  logic [3:0]        stamp_month_i,
  input  logic [4:0]        stamp_day_i,
  input  logic [4:0]        stamp_hour_i,
  input  logic [5:0]        stamp_minute_i,
  input  logic [5:0]        entry_index_i,
  output logic              ok_o,
  output logic [4:0]        short_used_o,
  output logic [5:0]        long_used_o,
  output logic [4:0]        perm_used_o,
  output logic [5:0]        removed_count_o,
  output logic [TagW-1:0]   out_content_o,
  output logic [TagW-1:0]   out_related_o,
  output logic [StampW-1:0] out_minutes_o
);

  logic [ToW-1:0] short_to_q, long_to_q;
  logic [1:0]     reg_idx;
  tte_cmd_t cmd;
  tte_sts_t sts;

  assign pready  = 1'b1;
  assign reg_idx = paddr[2] ? RegLongTo : RegShortTo;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      short_to_q <= ShortToReset;
      long_to_q  <= LongToReset;
    end else if (psel && penable && pwrite && pready) begin
      if (reg_idx == RegShortTo) short_to_q <= pwdata[ToW-1:0];
      else                       long_to_q  <= pwdata[ToW-1:0];
    end
  end

  always_comb begin
    case (reg_idx)
      RegShortTo: prdata = {12'd0, short_to_q};
      default:    prdata = {12'd0, long_to_q};
    endcase
  end

  tte_ctrl u_ctrl (
    .clk_i, .rst_ni, .start_i(start), .mode_i, .sts_i(sts),
    .busy_o(busy), .cmd_o(cmd)
  );

  tte_dp u_dp (
    .clk_i, .rst_ni, .cmd_i(cmd), .sts_o(sts),
    .mode_i, .mem_class_i, .content_tag_i, .related_tag_i,
    .stamp_year_i, .stamp_month_i, .stamp_day_i, .stamp_hour_i,
    .stamp_minute_i, .entry_index_i,
    .short_to_i(short_to_q), .long_to_i(long_to_q),
    .done_o, .ok_o, .short_used_o, .long_used_o, .perm_used_o,
    .removed_count_o, .out_content_o, .out_related_o, .out_minutes_o
  );

endmodule

@@ src/tte_ctrl.sv @@
// Controller state machine for the aging table.
module tte_ctrl import tte_pkg::*; (
  input  logic     clk_i,
  input  logic     rst_ni,
  input  logic     start_i,
  input  logic [1:0] mode_i,
  input  tte_sts_t sts_i,
  output logic     busy_o,
  output tte_cmd_t cmd_o
);

  typedef enum logic [2:0] {
    StIdle, StStamp1, StStamp2, StStamp3, StScan, StDone
  } state_e;

  state_e state_q;
  logic   clean_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= StIdle;
      clean_q <= 1'b0;
    end else begin
      case (state_q)
        StIdle: if (start_i) begin
          state_q <= StStamp1;
          clean_q <= (mode_i == ModeCleanup);
        end
        StStamp1: state_q <= StStamp2;
        StStamp2: state_q <= StStamp3;
        StStamp3: state_q <= clean_q ? StScan : StDone;
        StScan:   if (sts_i.scan_done) state_q <= StDone;
        StDone:   state_q <= StIdle;
        default:  state_q <= StIdle;
      endcase
    end
  end

  assign busy_o = (state_q != StIdle);

  always_comb begin
    cmd_o = '0;
    cmd_o.load       = (state_q == StIdle) && start_i;
    cmd_o.stamp_step = (state_q == StStamp1) || (state_q == StStamp2) ||
                       (state_q == StStamp3);
    cmd_o.scan_clr   = (state_q == StStamp3);
    cmd_o.scan_step  = (state_q == StScan) && !sts_i.scan_done;
    cmd_o.finish     = (state_q == StDone);
  end

endmodule

@@ src/tte_dp.sv @@
// Datapath: minute stamp, three tables, compaction scan and result registers.
module tte_dp import tte_pkg::*; (
  input  logic              clk_i,
  input  logic              rst_ni,
  input  tte_cmd_t          cmd_i,
  output tte_sts_t          sts_o,
  input  logic [1:0]        mode_i,
  input  logic [1:0]        mem_class_i,
  input  logic [TagW-1:0]   content_tag_i,
  input  logic [TagW-1:0]   related_tag_i,
  input  logic [13:0]       stamp_year_i,
  input  logic [3:0]        stamp_month_i,
  input  logic [4:0]        stamp_day_i,
  input  logic [4:0]        stamp_hour_i,
  input  logic [5:0]        stamp_minute_i,
  input  logic [5:0]        entry_index_i,
  input  logic [ToW-1:0]    short_to_i,
  input  logic [ToW-1:0]    long_to_i,
  output logic              done_o,
  output logic              ok_o,
  output logic [4:0]        short_used_o,
  output logic [5:0]        long_used_o,
  output logic [4:0]        perm_used_o,
  output logic [5:0]        removed_count_o,
  output logic [TagW-1:0]   out_content_o,
  output logic [TagW-1:0]   out_related_o,
  output logic [StampW-1:0] out_minutes_o
);

  localparam int unsigned EntW = 2*TagW + StampW;

  // floor(n / 25) for n below 4096: multiply by a rounded-up reciprocal of 25
  function automatic logic [7:0] div25(input logic [11:0] n);
    logic [24:0] p;
    p = 25'(n) * 25'd5243;
    return p[24:17];
  endfunction

  logic [1:0]      mode_q, cls_q;
  logic [TagW-1:0] cont_q, rel_q;
  logic [13:0]     year_q;
  logic [3:0]      month_q;
  logic [4:0]      day_q;
  logic [10:0]     hm_q;
  logic [5:0]      idx_q;

  // stage 1: year terms and day of year
  logic [13:0] ym1_q;
  logic [7:0]  c100_q, c400_q;
  logic [8:0]  doy_q;
  // stage 2: day count
  logic [DaysW-1:0] days_q;
  // stage 3: minute count
  logic [StampW+5:0] total_q;
  logic [StampW-1:0] stamp;

  logic [EntW-1:0] short_mem [ShortDepth];
  logic [EntW-1:0] long_mem  [LongDepth];
  logic [EntW-1:0] perm_mem  [PermDepth];
  logic [4:0] short_fill_q, perm_fill_q;
  logic [5:0] long_fill_q;

  // scan pointers: rd visits, wr keeps
  logic       scan_long_q, scan_long_d;
  logic [5:0] rd_q, rd_d, wr_q;
  logic [5:0] removed_q;

  // date math
  logic [13:0] y_fix, ym1;
  logic [3:0]  m_fix;
  logic [4:0]  d_fix;
  logic [7:0]  y_c100, c100_d, c400_d;
  logic        leap;
  logic [8:0]  doy_d;
  logic [DaysW-1:0] days_d;

  always_comb begin
    y_fix = (year_q == 14'd0) ? 14'd1 : year_q;
    m_fix = (month_q == 4'd0) ? 4'd1 :
            (month_q > 4'd12) ? 4'd12 : month_q;
    d_fix = (day_q == 5'd0) ? 5'd1 : day_q;
    ym1   = y_fix - 14'd1;
    // a multiple of four is a century year when its quarter is a multiple of 25
    y_c100 = div25(y_fix[13:2]);
    leap   = (y_fix[1:0] == 2'b00) &&
             ((y_fix[13:2] != 12'(y_c100) * 12'd25) || (y_c100[1:0] == 2'b00));
    c100_d = div25(ym1[13:2]);
    c400_d = div25({2'b00, ym1[13:4]});
    doy_d  = days_before(m_fix) + {8'd0, leap && (m_fix > 4'd2)}
           + {4'd0, d_fix} - 9'd1;
    days_d = DaysW'(ym1_q) * DaysW'(365) + DaysW'(ym1_q[13:2])
           - DaysW'(c100_q) + DaysW'(c400_q) + DaysW'(doy_q);
  end

  assign stamp = (total_q > (StampW+6)'(StampMax)) ? StampMax : total_q[StampW-1:0];

  // current scan entry
  logic [EntW-1:0]   cur_q;
  logic [5:0]        fill_cur;
  logic [ToW-1:0]    to_cur;
  logic              expired;
  logic [StampW:0]   age;
  always_comb begin
    fill_cur = scan_long_q ? long_fill_q : {1'b0, short_fill_q};
    to_cur   = scan_long_q ? long_to_i : short_to_i;
    age      = {1'b0, stamp} - {1'b0, cur_q[StampW-1:0]};
    expired  = !age[StampW] && (age[StampW-1:0] > StampW'(to_cur));
  end
  assign sts_o.scan_done = scan_long_q && (rd_q >= long_fill_q);

  // next scan position; the entry there is fetched at the same edge
  always_comb begin
    scan_long_d = scan_long_q;
    rd_d        = rd_q;
    if (cmd_i.scan_clr) begin
      scan_long_d = 1'b0;
      rd_d        = '0;
    end else if (cmd_i.scan_step) begin
      if (rd_q >= fill_cur) begin
        scan_long_d = 1'b1;
        rd_d        = '0;
      end else begin
        rd_d = rd_q + 6'd1;
      end
    end
  end

  // read selection
  logic [EntW-1:0] rd_ent_q;
  logic            rd_ok;
  always_comb begin
    case (cls_q)
      ClsShort: rd_ok = idx_q < 6'(short_fill_q);
      ClsLong:  rd_ok = idx_q < long_fill_q;
      ClsPerm:  rd_ok = idx_q < 6'(perm_fill_q);
      default:  rd_ok = 1'b0;
    endcase
  end

  logic add_ok;
  always_comb begin
    case (cls_q)
      ClsShort: add_ok = short_fill_q < 5'(ShortDepth);
      ClsLong:  add_ok = long_fill_q  < 6'(LongDepth);
      ClsPerm:  add_ok = perm_fill_q  < 5'(PermDepth);
      default:  add_ok = 1'b0;
    endcase
  end

  always_ff @(posedge clk_i) begin
    if (cmd_i.load) begin
      mode_q  <= mode_i;
      cls_q   <= mem_class_i;
      cont_q  <= content_tag_i;
      rel_q   <= related_tag_i;
      year_q  <= stamp_year_i;
      month_q <= stamp_month_i;
      day_q   <= stamp_day_i;
      hm_q    <= 11'(stamp_hour_i) * 11'd60 + 11'(stamp_minute_i);
      idx_q   <= entry_index_i;
    end
    if (cmd_i.stamp_step) begin
      ym1_q   <= ym1;
      c100_q  <= c100_d;
      c400_q  <= c400_d;
      doy_q   <= doy_d;
      days_q  <= days_d;
      total_q <= (StampW+6)'(days_q) * (StampW+6)'(1440) + (StampW+6)'(hm_q);
    end
    cur_q <= scan_long_d ? long_mem[rd_d[LongAw-1:0]] : short_mem[rd_d[ShortAw-1:0]];
    case (cls_q)
      ClsShort: rd_ent_q <= short_mem[idx_q[ShortAw-1:0]];
      ClsLong:  rd_ent_q <= long_mem[idx_q[LongAw-1:0]];
      default:  rd_ent_q <= perm_mem[idx_q[PermAw-1:0]];
    endcase
    if (cmd_i.scan_step && !expired && rd_q < fill_cur) begin
      if (scan_long_q) long_mem[wr_q[LongAw-1:0]] <= cur_q;
      else             short_mem[wr_q[ShortAw-1:0]] <= cur_q;
    end
    if (cmd_i.finish && mode_q == ModeAdd && add_ok) begin
      case (cls_q)
        ClsShort: short_mem[short_fill_q[ShortAw-1:0]] <= {cont_q, rel_q, stamp};
        ClsLong:  long_mem[long_fill_q[LongAw-1:0]]    <= {cont_q, rel_q, stamp};
        ClsPerm:  perm_mem[perm_fill_q[PermAw-1:0]]    <= {cont_q, rel_q, stamp};
        default: ;
      endcase
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      short_fill_q <= '0;
      long_fill_q  <= '0;
      perm_fill_q  <= '0;
      scan_long_q  <= 1'b0;
      rd_q <= '0;
      wr_q <= '0;
      removed_q <= '0;
      done_o <= 1'b0;
      ok_o <= 1'b0;
      short_used_o <= '0;
      long_used_o <= '0;
      perm_used_o <= '0;
      removed_count_o <= '0;
      out_content_o <= '0;
      out_related_o <= '0;
      out_minutes_o <= '0;
    end else begin
      done_o <= 1'b0;
      scan_long_q <= scan_long_d;
      rd_q <= rd_d;
      if (cmd_i.scan_clr) begin
        wr_q <= '0;
        removed_q <= '0;
      end
      if (cmd_i.scan_step) begin
        if (rd_q >= fill_cur) begin
          // table done: commit fill, move to long table
          if (!scan_long_q) short_fill_q <= wr_q[4:0];
          wr_q <= '0;
        end else begin
          if (expired) removed_q <= removed_q + 6'd1;
          else         wr_q <= wr_q + 6'd1;
        end
      end
      if (cmd_i.finish) begin
        logic [4:0] sf, pf;
        logic [5:0] lf;
        sf = short_fill_q;
        lf = long_fill_q;
        pf = perm_fill_q;
        done_o <= 1'b1;
        ok_o <= 1'b0;
        removed_count_o <= '0;
        out_content_o <= '0;
        out_related_o <= '0;
        out_minutes_o <= '0;
        case (mode_q)
          ModeAdd: if (add_ok) begin
            ok_o <= 1'b1;
            case (cls_q)
              ClsShort: sf = sf + 5'd1;
              ClsLong:  lf = lf + 6'd1;
              default:  pf = pf + 5'd1;
            endcase
          end
          ModeCleanup: begin
            ok_o <= 1'b1;
            lf = wr_q;
            removed_count_o <= removed_q;
          end
          ModeRead: if (rd_ok) begin
            ok_o <= 1'b1;
            out_content_o <= rd_ent_q[EntW-1 -: TagW];
            out_related_o <= rd_ent_q[StampW +: TagW];
            out_minutes_o <= rd_ent_q[StampW-1:0];
          end
          default: ;
        endcase
        short_fill_q <= sf;
        long_fill_q  <= lf;
        perm_fill_q  <= pf;
        short_used_o <= sf;
        long_used_o  <= lf;
        perm_used_o  <= pf;
      end
    end
  end

endmodule

@@ bench/tte_checker.sv @@
// Checker for the aging table: snoops register writes and commands, predicts and compares results.
module tte_checker import tte_pkg::*; (
  input  logic              clk_i,
  input  logic              rst_ni,
  input  logic              psel,
  input  logic              penable,
  input  logic              pwrite,
  input  logic              pready,
  input  logic [2:0]        paddr,
  input  logic [31:0]       pwdata,
  input  logic              start,
  input  logic              busy,
  input  logic              done_o,
  input  logic [1:0]        mode_i,
  input  logic [1:0]        mem_class_i,
  input  logic [TagW-1:0]   content_tag_i,
  input  logic [TagW-1:0]   related_tag_i,
  input  logic [13:0]       stamp_year_i,
  input  logic [3:0]        stamp_month_i,
  input  logic [4:0]        stamp_day_i,
  input  logic [4:0]        stamp_hour_i,
  input  logic [5:0]        stamp_minute_i,
  input  logic [5:0]        entry_index_i,
  input  logic              ok_o,
  input  logic [4:0]        short_used_o,
  input  logic [5:0]        long_used_o,
  input  logic [4:0]        perm_used_o,
  input  logic [5:0]        removed_count_o,
  input  logic [TagW-1:0]   out_content_o,
  input  logic [TagW-1:0]   out_related_o,
  input  logic [StampW-1:0] out_minutes_o,
  output int                fails,
  output int                pending
);

  typedef struct {
    logic [TagW-1:0]   content;
    logic [TagW-1:0]   related;
    logic [StampW-1:0] minutes;
  } entry_t;

  typedef struct {
    logic              ok;
    logic [4:0]        short_cnt;
    logic [5:0]        long_cnt;
    logic [4:0]        perm_cnt;
    logic [5:0]        removed;
    logic [TagW-1:0]   content;
    logic [TagW-1:0]   related;
    logic [StampW-1:0] minutes;
  } outcome_t;

  entry_t short_tab[ShortDepth];
  entry_t long_tab[LongDepth];
  entry_t perm_tab[PermDepth];
  int unsigned short_n, long_n, perm_n;
  logic [ToW-1:0] short_to, long_to;
  outcome_t outcome_q[$];

  assign pending = outcome_q.size();

  function automatic logic [StampW-1:0] to_minutes(logic [13:0] yr, logic [3:0] mo,
                                                  logic [4:0] dy, logic [4:0] hr,
                                                  logic [5:0] mn);
    int unsigned mlen[13] = '{0, 31, 28, 31, 30, 31, 30, 31, 31, 30, 31, 30, 31};
    longint unsigned y, m, d, days, total;
    bit leap;
    y = (yr == 0) ? 1 : yr;
    m = (mo == 0) ? 1 : ((mo > 12) ? 12 : mo);
    d = (dy == 0) ? 1 : dy;
    leap = (y % 4 == 0) && ((y % 100 != 0) || (y % 400 == 0));
    days = 365 * (y - 1) + (y - 1) / 4 - (y - 1) / 100 + (y - 1) / 400;
    for (int i = 1; i < m; i++) begin
      days += mlen[i];
      if (i == 2 && leap) days += 1;
    end
    days += d - 1;
    total = days * 1440 + hr * 60 + mn;
    return (total > 64'h1_FFFF_FFFF) ? StampMax : total[StampW-1:0];
  endfunction

  task automatic report(string what, longint unsigned got, longint unsigned want);
    $display("mismatch %s: got %0d expected %0d at %0t", what, got, want, $realtime);
    fails++;
  endtask

  function automatic outcome_t apply_command();
    outcome_t r;
    logic [StampW-1:0] now;
    int unsigned kept;
    longint age;
    r = '{default: '0};
    now = to_minutes(stamp_year_i, stamp_month_i, stamp_day_i, stamp_hour_i,
                     stamp_minute_i);
    case (mode_i)
      ModeAdd: begin
        if (mem_class_i == ClsShort && short_n < ShortDepth) begin
          short_tab[short_n] = '{content_tag_i, related_tag_i, now};
          short_n++;
          r.ok = 1;
        end else if (mem_class_i == ClsLong && long_n < LongDepth) begin
          long_tab[long_n] = '{content_tag_i, related_tag_i, now};
          long_n++;
          r.ok = 1;
        end else if (mem_class_i == ClsPerm && perm_n < PermDepth) begin
          perm_tab[perm_n] = '{content_tag_i, related_tag_i, now};
          perm_n++;
          r.ok = 1;
        end
      end
      ModeCleanup: begin
        // compact in order, drop entries older than the timeout
        kept = 0;
        for (int i = 0; i < short_n; i++) begin
          age = longint'(now) - longint'(short_tab[i].minutes);
          if (age <= longint'(short_to)) begin
            short_tab[kept] = short_tab[i];
            kept++;
          end
        end
        r.removed = 6'(short_n - kept);
        short_n = kept;
        kept = 0;
        for (int i = 0; i < long_n; i++) begin
          age = longint'(now) - longint'(long_tab[i].minutes);
          if (age <= longint'(long_to)) begin
            long_tab[kept] = long_tab[i];
            kept++;
          end
        end
        r.removed = r.removed + 6'(long_n - kept);
        long_n = kept;
        r.ok = 1;
      end
      ModeRead: begin
        if (mem_class_i == ClsShort && entry_index_i < short_n) begin
          r.ok = 1;
          {r.content, r.related, r.minutes} = {short_tab[entry_index_i].content,
            short_tab[entry_index_i].related, short_tab[entry_index_i].minutes};
        end else if (mem_class_i == ClsLong && entry_index_i < long_n) begin
          r.ok = 1;
          {r.content, r.related, r.minutes} = {long_tab[entry_index_i].content,
            long_tab[entry_index_i].related, long_tab[entry_index_i].minutes};
        end else if (mem_class_i == ClsPerm && entry_index_i < perm_n) begin
          r.ok = 1;
          {r.content, r.related, r.minutes} = {perm_tab[entry_index_i].content,
            perm_tab[entry_index_i].related, perm_tab[entry_index_i].minutes};
        end
      end
      default: ;
    endcase
    r.short_cnt = 5'(short_n);
    r.long_cnt = 6'(long_n);
    r.perm_cnt = 5'(perm_n);
    return r;
  endfunction

  always @(posedge clk_i or negedge rst_ni) begin
    outcome_t w;
    if (!rst_ni) begin
      short_n = 0;
      long_n = 0;
      perm_n = 0;
      short_to = ShortToReset;
      long_to = LongToReset;
      fails = 0;
    end else begin
      if (psel && penable && pwrite && pready) begin
        if (paddr[2:2] == RegShortTo[0:0]) short_to = pwdata[ToW-1:0];
        else if (paddr[2:2] == RegLongTo[0:0]) long_to = pwdata[ToW-1:0];
      end
      if (done_o) begin
        if (outcome_q.size() == 0) begin
          report("unexpected result", 0, 0);
        end else begin
          w = outcome_q.pop_front();
          if (ok_o !== w.ok) report("ok", ok_o, w.ok);
          if (short_used_o !== w.short_cnt) report("short_used", short_used_o, w.short_cnt);
          if (long_used_o !== w.long_cnt) report("long_used", long_used_o, w.long_cnt);
          if (perm_used_o !== w.perm_cnt) report("perm_used", perm_used_o, w.perm_cnt);
          if (removed_count_o !== w.removed) report("removed_count", removed_count_o, w.removed);
          if (out_content_o !== w.content) report("out_content", out_content_o, w.content);
          if (out_related_o !== w.related) report("out_related", out_related_o, w.related);
          if (out_minutes_o !== w.minutes) report("out_minutes", out_minutes_o, w.minutes);
        end
      end
      if (start && !busy) outcome_q.push_back(apply_command());
    end
  end

endmodule

@@ bench/testbench.sv @@
// Testbench top: drives commands and register writes into the aging table and gives the verdict.
module testbench import tte_pkg::*; ();

  localparam int IdleLimit = 5000;

  logic clk_i = 0;
  logic rst_ni = 0;
  logic psel = 0, penable = 0, pwrite = 0;
  logic [2:0] paddr = '0;
  logic [31:0] pwdata = '0;
  logic [31:0] prdata;
  logic pready;
  logic start = 0;
  logic busy, done_o;
  logic [1:0] mode_i = '0, mem_class_i = '0;
  logic [TagW-1:0] content_tag_i = '0, related_tag_i = '0;
  logic [13:0] stamp_year_i = '0;
  logic [3:0] stamp_month_i = '0;
  logic [4:0] stamp_day_i = '0, stamp_hour_i = '0;
  logic [5:0] stamp_minute_i = '0, entry_index_i = '0;
  logic ok_o;
  logic [4:0] short_used_o, perm_used_o;
  logic [5:0] long_used_o, removed_count_o;
  logic [TagW-1:0] out_content_o, out_related_o;
  logic [StampW-1:0] out_minutes_o;
  int fails, pending;
  int idle_cycles = 0;
  int gap_pct = 0;

  always begin
    #4 clk_i = 1;
    #4 clk_i = 0;
  end

  timestamped_table_with_expiry i_dut (.*);
  tte_checker i_checker (.*);

  always @(posedge clk_i) begin
    if ((start && !busy) || done_o || (psel && penable)) idle_cycles <= 0;
    else idle_cycles <= idle_cycles + 1;
    if (idle_cycles >= IdleLimit) begin
      $display("tb: failure");
      $finish;
    end
  end

  task automatic reg_write(logic [1:0] idx, logic [ToW-1:0] value);
    @(negedge clk_i);
    psel = 1;
    penable = 0;
    pwrite = 1;
    paddr = 3'(idx) << 2;
    pwdata = {12'($urandom), value};
    @(negedge clk_i);
    penable = 1;
    @(negedge clk_i);
    psel = 0;
    penable = 0;
    pwrite = 0;
  endtask

  // hold start high until the command is taken; called right after a negedge
  task automatic issue(logic [1:0] md, logic [1:0] cls, logic [31:0] ct, logic [31:0] rt,
                       logic [13:0] yr, logic [3:0] mo, logic [4:0] dy, logic [4:0] hr,
                       logic [5:0] mn, logic [5:0] ix);
    bit taken;
    while (gap_pct > 0 && $urandom_range(99) < gap_pct) begin
      start = 0;
      @(negedge clk_i);
    end
    {mode_i, mem_class_i, content_tag_i, related_tag_i} = {md, cls, ct, rt};
    {stamp_year_i, stamp_month_i, stamp_day_i, stamp_hour_i} = {yr, mo, dy, hr};
    {stamp_minute_i, entry_index_i} = {mn, ix};
    start = 1;
    taken = 0;
    while (!taken) begin
      taken = !busy;
      @(negedge clk_i);
    end
  endtask

  task automatic random_item();
    logic [1:0] md, cls;
    int r;
    r = $urandom_range(99);
    md = (r < 45) ? ModeAdd : (r < 60) ? ModeCleanup : (r < 95) ? ModeRead : ModeNone;
    cls = ($urandom_range(9) == 0) ? ClsNone : 2'($urandom_range(2));
    if ($urandom_range(9) == 0)
      issue(md, 2'($urandom), $urandom, $urandom, 14'($urandom), 4'($urandom), 5'($urandom),
            5'($urandom), 6'($urandom), 6'($urandom));
    else
      issue(md, cls, $urandom, $urandom, 14'd2020, 4'($urandom_range(2, 3)),
            5'($urandom_range(1, 3)), 5'($urandom_range(23)), 6'($urandom_range(59)),
            6'($urandom_range(33)));
  endtask

  task automatic drain();
    @(negedge clk_i);
    start = 0;
    while (pending != 0) @(negedge clk_i);
    repeat (80) @(negedge clk_i);
  endtask

  initial begin
    logic [ToW-1:0] short_set[5] = '{ShortToReset, 20'd0, 20'hFFFFF, 20'd0, 20'd600};
    logic [ToW-1:0] long_set[5] = '{LongToReset, 20'd0, 20'hFFFFF, 20'd0, 20'd2000};
    repeat (12) @(posedge clk_i);
    @(negedge clk_i);
    rst_ni = 1;
    reg_write(RegShortTo, short_set[0]);
    reg_write(RegLongTo, long_set[0]);
    @(negedge clk_i);
    // extremes and corner cases
    issue(ModeRead, ClsShort, 0, 0, 1, 1, 1, 0, 0, 0);
    issue(ModeNone, ClsShort, '1, '1, '1, '1, '1, '1, '1, '1);
    issue(ModeAdd, ClsNone, '1, '1, 2020, 1, 1, 0, 0, 0);
    issue(ModeAdd, ClsShort, '1, '1, 0, 0, 0, 0, 0, 0);
    issue(ModeAdd, ClsShort, 0, 0, '1, '1, '1, '1, '1, 0);
    issue(ModeAdd, ClsLong, 32'h5555_AAAA, 32'hAAAA_5555, 9999, 12, 31, 23, 59, 0);
    issue(ModeAdd, ClsPerm, 32'h1234_5678, 32'h8765_4321, 2000, 2, 29, 12, 30, 0);
    issue(ModeAdd, ClsLong, 1, 2, 1900, 3, 1, 0, 0, 0);
    issue(ModeAdd, ClsShort, 3, 4, 2024, 3, 1, 8, 0, 0);
    issue(ModeRead, ClsShort, 0, 0, 1, 1, 1, 0, 0, 0);
    issue(ModeRead, ClsShort, 0, 0, 1, 1, 1, 0, 0, 1);
    issue(ModeRead, ClsLong, 0, 0, 1, 1, 1, 0, 0, 1);
    issue(ModeRead, ClsPerm, 0, 0, 1, 1, 1, 0, 0, 0);
    issue(ModeRead, ClsPerm, 0, 0, 1, 1, 1, 0, 0, 1);
    issue(ModeRead, ClsNone, 0, 0, 1, 1, 1, 0, 0, 0);
    issue(ModeRead, ClsLong, 0, 0, 1, 1, 1, 0, 0, 63);
    issue(ModeCleanup, ClsNone, 0, 0, 2024, 3, 1, 15, 59, 0);
    issue(ModeCleanup, ClsShort, 0, 0, 2024, 3, 1, 16, 1, 0);
    issue(ModeCleanup, ClsLong, 0, 0, 0, 0, 0, 0, 0, 0);
    issue(ModeCleanup, ClsPerm, 0, 0, '1, '1, '1, '1, '1, 0);
    issue(ModeRead, ClsPerm, 0, 0, 1, 1, 1, 0, 0, 1);
    drain();
    for (int ph = 0; ph < 5; ph++) begin
      if (ph > 0) begin
        reg_write(RegShortTo, (ph == 3) ? 20'($urandom_range(3000)) : short_set[ph]);
        reg_write(RegLongTo, (ph == 3) ? 20'($urandom_range(5000)) : long_set[ph]);
        @(negedge clk_i);
      end
      for (int n = 0; n < 350; n++) begin
        int k;
        k = ph * 350 + n;
        gap_pct = (k < 580) ? 27 : (k < 1160) ? 53 : 0;
        random_item();
      end
      drain();
    end
    if (fails == 0) $display("tb: success");
    else $display("tb: failure");
    $finish;
  end

endmodule
